>>> src/cue_pkg.sv
// Package for the condensed UUID encoder: constants, FSM state type, command/status structs.
// Depends on nothing; used by cue_ctrl, cue_dp and condensed_uuid_encoder_unit.
package cue_pkg;

  localparam logic [63:0] BASE_2016 = 64'h01b21dd213814000 + 64'd46 * 64'h00011f0241243c00;
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [47:0] MCAST_BIT = 48'h010000000000;

  localparam logic [1:0] KIND_FULL = 2'd0;
  localparam logic [1:0] KIND_COMPACT = 2'd1;
  localparam logic [1:0] KIND_EXPANDED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_HASH,
    ST_SEED,
    ST_TWIST,
    ST_TEMP,
    ST_LAYOUT,
    ST_STRIP,
    ST_PREFIX,
    ST_EMIT
  } cue_state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic hash_step;
    logic seed_step;
    logic twist;
    logic temper;
    logic layout;
    logic strip_step;
    logic prefix;
    logic emit_step;
  } cue_cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic condense;
    logic zero_fields;
    logic hash_done;
    logic seed_done;
    logic strip_done;
    logic emit_last;
  } cue_sts_t;

  // Prefix code table: {len code, len mask, alt code, alt mask} per length.
  function automatic logic [31:0] len_code(input logic [3:0] idx);
    case (idx)
      4'd0: len_code = 32'h1cfc1cfc;
      4'd1: len_code = 32'h18fc18fc;
      4'd2: len_code = 32'h14fc14fc;
      4'd3: len_code = 32'h10fc10fc;
      4'd4: len_code = 32'h04fc40c0;
      4'd5: len_code = 32'h0afea0e0;
      4'd6: len_code = 32'h08fe80e0;
      4'd7: len_code = 32'h02ff20f0;
      4'd8: len_code = 32'h03ff30f0;
      4'd9: len_code = 32'h0cffc0f0;
      4'd10: len_code = 32'h0dffd0f0;
      4'd11: len_code = 32'h0effe0f0;
      4'd12: len_code = 32'h0ffff0f0;
      default: len_code = 32'h0ffff0f0;
    endcase
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] yi);
    logic [31:0] y;
    y = yi;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    temper = y;
  endfunction

  function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] r;
    y = {a[31], b[30:0]};
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ 32'h9908b0df;
    end
    twist = r;
  endfunction

endpackage

>>> src/condensed_uuid_encoder_unit.sv
// Top level of the condensed UUID encoder: joins the controller and the datapath.
// Depends on cue_pkg, cue_ctrl and cue_dp.
//
// Usage: one UUID is a transfer on the in_ channel (in_uuid_high, in_uuid_low).
// The block answers with 4 to 17 byte transfers on the out_ channel, last_byte
// high on the final one and form_kind constant across the UUID.
// One UUID is handled at a time; in_ready is high only when the block is idle.
// A UUID that is not RFC 4122 version 1 is accepted and decoded, then sent one
// byte per cycle while the receiver takes them.
// A condensed UUID is accepted and decoded, hashed, seeded (one 32-bit multiply
// per seeding step, the MT19937 initialization recurrence), twisted, tempered,
// laid out, stripped of leading zero bytes and prefixed with its length, then
// sent one byte per cycle while the receiver takes them. When the condensed
// time, clock and salt are all zero, hashing, seeding, twist and temper are skipped.
// Reset returns the controller to idle; buffers need no clearing.
// When the receiver stalls, the current byte is held until it is taken.
module condensed_uuid_encoder_unit
  import cue_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_uuid_high,
  input  logic [63:0] in_uuid_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_last_byte,
  output logic [1:0]  out_form_kind
);

  cue_cmd_t cmd;
  cue_sts_t sts;

  cue_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .sts(sts), .cmd(cmd)
  );

  cue_dp u_dp (
    .clk(clk), .in_uuid_high(in_uuid_high), .in_uuid_low(in_uuid_low),
    .cmd(cmd), .sts(sts), .out_byte(out_out_byte), .last_byte(out_last_byte),
    .form_kind(out_form_kind)
  );

endmodule

>>> src/cue_ctrl.sv
// Controller FSM for the condensed UUID encoder: sequences hashing, seeding and output.
// Depends on cue_pkg.
module cue_ctrl
  import cue_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  cue_sts_t sts,
  output cue_cmd_t cmd
);

  cue_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: begin
        if (!sts.condense) state_nxt = ST_EMIT;
        else if (sts.zero_fields) state_nxt = ST_LAYOUT;
        else state_nxt = ST_HASH;
      end
      ST_HASH: if (sts.hash_done) state_nxt = ST_SEED;
      ST_SEED: if (sts.seed_done) state_nxt = ST_TWIST;
      ST_TWIST: state_nxt = ST_TEMP;
      ST_TEMP: state_nxt = ST_LAYOUT;
      ST_LAYOUT: state_nxt = ST_STRIP;
      ST_STRIP: if (sts.strip_done) state_nxt = ST_PREFIX;
      ST_PREFIX: state_nxt = ST_EMIT;
      ST_EMIT: if (out_ready && sts.emit_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_HASH: cmd.hash_step = 1'b1;
      ST_SEED: cmd.seed_step = 1'b1;
      ST_TWIST: cmd.twist = 1'b1;
      ST_TEMP: cmd.temper = 1'b1;
      ST_LAYOUT: cmd.layout = 1'b1;
      ST_STRIP: cmd.strip_step = 1'b1;
      ST_PREFIX: cmd.prefix = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit_step = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> src/cue_dp.sv
// Datapath for the condensed UUID encoder: FNV hash, MT19937 seeding, layout and byte buffer.
// Depends on cue_pkg.
module cue_dp
  import cue_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] in_uuid_high,
  input  logic [63:0] in_uuid_low,
  input  cue_cmd_t    cmd,
  output cue_sts_t    sts,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic [1:0]  form_kind
);

  // FNV prime multiply, 2^40 + 0x1b3, written as shifts and adds.
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  logic [63:0]  hi_r, lo_r;
  logic [45:0]  ct_r;
  logic [13:0]  cclk_r;
  logic [59:0]  time_r;
  // Hash engine: three FNV-1a streams run in parallel, one byte per cycle.
  logic [63:0]  hv_r [3];
  logic [63:0]  hh_r [3];
  logic [3:0]   hcnt_r;
  // Seeding: one multiply per cycle.
  logic [31:0]  x_r, w0_r, w1_r, w2_r, w3_r, w4_r;
  logic [8:0]   i_r;
  logic [31:0]  tw_hi_r, tw_lo_r;
  logic [47:0]  node_gen_r;
  logic [1:0]   kind_r;
  logic [7:0]   buf_r [17];
  logic [4:0]   pos_r;
  logic [4:0]   start_r;

  logic [47:0] node;
  logic [13:0] clock;
  logic [59:0] time_raw;
  logic [59:0] ct_full;
  logic [6:0]  salt;
  assign node = lo_r[47:0];
  assign clock = lo_r[61:48];
  assign time_raw = {hi_r[11:0], hi_r[31:16], hi_r[63:32]};
  assign salt = node[6:0];
  assign ct_full = (time_raw != '0) ? 60'(time_raw - BASE_2016[59:0]) : '0;

  logic [63:0] b0, b1;
  logic [3:0]  len;
  logic [7:0]  lead;
  logic [31:0] lc, lc2;
  logic [3:0]  len2;
  logic [31:0] seed_prod;
  logic [31:0] xs;
  logic [31:0] tmp_hi, tmp_lo;

  assign xs = x_r ^ (x_r >> 30);
  assign seed_prod = 32'd1812433253 * xs + {23'd0, i_r};
  assign tmp_hi = temper(tw_hi_r);
  assign tmp_lo = temper(tw_lo_r);

  // Layout words for the condensed forms.
  always_comb begin
    logic [63:0] v0, v1;
    logic [59:0] tm;
    tm = time_r;
    if (node_gen_r == node) begin
      v0 = {18'd0, ct_r};
      v1 = {cclk_r, salt, 42'd0, 1'b1};
      b0 = v0 >> 42;
      b1 = (v0 << 22) | (v1 >> 42) | 64'd1;
    end else begin
      if (!node[40] && time_r != '0) tm = 60'(time_r - BASE_2016[59:0]);
      v0 = {4'd0, tm};
      v1 = {clock, node, 2'd0};
      b0 = v0 >> 1;
      b1 = (v0 << 63) | (v1 >> 1);
    end
  end

  assign len = 4'(5'd13 - start_r);
  assign lead = buf_r[start_r];
  assign lc = len_code(len);
  assign len2 = (len + 4'd1 > 4'd12) ? 4'd12 : len + 4'd1;
  assign lc2 = len_code(len2);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_r <= in_uuid_high;
      lo_r <= in_uuid_low;
    end
    if (cmd.prep) begin
      ct_r <= ct_full[59:14];
      cclk_r <= clock ^ ct_full[13:0];
      time_r <= time_raw;
      hv_r[0] <= {18'd0, ct_full[59:14]};
      hv_r[1] <= {50'd0, clock ^ ct_full[13:0]};
      hv_r[2] <= {57'd0, salt};
      for (int k = 0; k < 3; k++) hh_r[k] <= FNV_BASIS;
      hcnt_r <= '0;
      node_gen_r <= MCAST_BIT;
      kind_r <= KIND_FULL;
      start_r <= '0;
      pos_r <= '0;
      buf_r[0] <= 8'h01;
      for (int k = 0; k < 8; k++) begin
        buf_r[1 + k] <= hi_r[63 - 8 * k -: 8];
        buf_r[9 + k] <= lo_r[63 - 8 * k -: 8];
      end
    end
    // FNV-1a, one byte of each stream per cycle.
    if (cmd.hash_step) begin
      for (int k = 0; k < 3; k++) begin
        if (hv_r[k] != '0) begin
          hh_r[k] <= fnv_mul(hh_r[k] ^ {56'd0, hv_r[k][7:0]});
          hv_r[k] <= hv_r[k] >> 8;
        end
      end
      hcnt_r <= hcnt_r + 4'd1;
      x_r <= 32'(hh_r[0] ^ hh_r[1] ^ hh_r[2]);
      i_r <= 9'd1;
    end
    // MT19937 init recurrence, keeping only needed words.
    if (cmd.seed_step) begin
      if (i_r == 9'd1) w0_r <= x_r;
      x_r <= seed_prod;
      i_r <= i_r + 9'd1;
      if (i_r == 9'd1) w1_r <= seed_prod;
      if (i_r == 9'd2) w2_r <= seed_prod;
      if (i_r == 9'd397) w3_r <= seed_prod;
      if (i_r == 9'd398) w4_r <= seed_prod;
    end
    if (cmd.twist) begin
      tw_hi_r <= twist(w0_r, w1_r, w3_r);
      tw_lo_r <= twist(w1_r, w2_r, w4_r);
    end
    if (cmd.temper) begin
      node_gen_r <= {tmp_hi[15:9], 1'b1, tmp_hi[7:0], tmp_lo[31:7], salt};
    end
    if (cmd.layout) begin
      kind_r <= (node_gen_r == node) ? KIND_COMPACT : KIND_EXPANDED;
      buf_r[0] <= 8'h00;
      for (int k = 0; k < 8; k++) begin
        buf_r[1 + k] <= b0[63 - 8 * k -: 8];
        buf_r[9 + k] <= b1[63 - 8 * k -: 8];
      end
      start_r <= 5'd1;
    end
    if (cmd.strip_step && !sts.strip_done) start_r <= start_r + 5'd1;
    // Merge the length prefix into the lead byte or one byte in front of it.
    if (cmd.prefix) begin
      if ((lead & lc[23:16]) != '0) begin
        if ((lead & lc[7:0]) != '0) begin
          start_r <= start_r - 5'd1;
          buf_r[start_r - 5'd1] <= buf_r[start_r - 5'd1] | lc2[31:24];
        end else begin
          buf_r[start_r] <= lead | lc[15:8];
        end
      end else begin
        buf_r[start_r] <= lead | lc[31:24];
      end
      pos_r <= '0;
    end
    if (cmd.emit_step) pos_r <= pos_r + 5'd1;
  end

  logic [4:0] rd;
  assign rd = start_r + pos_r;
  assign out_byte = buf_r[rd];
  assign last_byte = (rd == 5'd16);
  assign form_kind = kind_r;

  assign sts.condense = (lo_r[63:62] == 2'b10) && (hi_r[15:12] == 4'd1);
  assign sts.zero_fields = (ct_full[59:14] == '0) && ((clock ^ ct_full[13:0]) == '0)
                           && (salt == '0);
  assign sts.hash_done = (hcnt_r == 4'd8);
  assign sts.seed_done = (i_r == 9'd398);
  assign sts.strip_done = (start_r >= 5'd13) || (buf_r[start_r] != 8'h00);
  assign sts.emit_last = last_byte;

endmodule

>>> tb/sv/tb_condensed_uuid_encoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for condensed_uuid_encoder_unit: random and directed UUIDs,
// a byte-level predictor of the serialised form, and randomly stalling handshakes.
// Depends on cue_pkg and the RTL of condensed_uuid_encoder_unit.
module tb_condensed_uuid_encoder_unit
  import cue_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam logic [63:0] TIME60 = 64'h0fffffffffffffff;
  localparam logic [63:0] NODE48 = 64'h0000ffffffffffff;
  localparam logic [63:0] MCAST64 = 64'h0000010000000000;

  // Length prefix table: code, mask, alternate code, alternate mask.
  localparam logic [7:0] PREFIX_TBL [13][4] = '{
    '{8'h1c, 8'hfc, 8'h1c, 8'hfc}, '{8'h18, 8'hfc, 8'h18, 8'hfc},
    '{8'h14, 8'hfc, 8'h14, 8'hfc}, '{8'h10, 8'hfc, 8'h10, 8'hfc},
    '{8'h04, 8'hfc, 8'h40, 8'hc0}, '{8'h0a, 8'hfe, 8'ha0, 8'he0},
    '{8'h08, 8'hfe, 8'h80, 8'he0}, '{8'h02, 8'hff, 8'h20, 8'hf0},
    '{8'h03, 8'hff, 8'h30, 8'hf0}, '{8'h0c, 8'hff, 8'hc0, 8'hf0},
    '{8'h0d, 8'hff, 8'hd0, 8'hf0}, '{8'h0e, 8'hff, 8'he0, 8'hf0},
    '{8'h0f, 8'hff, 8'hf0, 8'hf0}
  };

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    bit          drain_first;
  } uuid_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [1:0] kind;
  } ser_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_uuid_high = '0;
  logic [63:0] in_uuid_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_last_byte;
  logic [1:0]  out_form_kind;

  uuid_item_t  uuid_q[$];
  ser_byte_t   ser_q[$];
  int unsigned cyc = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;

  condensed_uuid_encoder_unit dut (.*);

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // FNV-1a over the bytes of a value, low byte first, stopping at zero.
  function automatic logic [63:0] fnv_hash(input logic [63:0] v);
    logic [63:0] h;
    h = FNV_BASIS;
    while (v != 0) begin
      h = (h ^ {56'd0, v[7:0]}) * FNV_PRIME;
      v = v >> 8;
    end
    return h;
  endfunction

  function automatic logic [31:0] mt_temper(input logic [31:0] y);
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    return y ^ (y >> 18);
  endfunction

  function automatic logic [31:0] mt_twist(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] far);
    logic [31:0] y;
    y = {a[31], b[30:0]};
    return (far ^ (y >> 1)) ^ (y[0] ? 32'h9908b0df : 32'h0);
  endfunction

  // Node regenerated from condensed time, clock and salt.
  function automatic logic [63:0] node_from_fields(input logic [63:0] t, input logic [63:0] c,
                                                   input logic [63:0] s);
    logic [31:0] x;
    logic [31:0] w [5];
    logic [63:0] node;
    if (t == 0 && c == 0 && s == 0) return MCAST64;
    x = 32'(fnv_hash(t) ^ fnv_hash(c) ^ fnv_hash(s));
    w[0] = x;
    for (int unsigned i = 1; i <= 398; i++) begin
      x = 32'd1812433253 * (x ^ (x >> 30)) + i;
      if (i == 1) w[1] = x;
      else if (i == 2) w[2] = x;
      else if (i == 397) w[3] = x;
      else if (i == 398) w[4] = x;
    end
    node = {mt_temper(mt_twist(w[0], w[1], w[3])), mt_temper(mt_twist(w[1], w[2], w[4]))};
    node = node & NODE48 & ~64'h7f;
    return node | s | MCAST64;
  endfunction

  function automatic logic [63:0] rebase(input logic [63:0] t);
    return (t != 0) ? ((t - BASE_2016) & TIME60) : 64'd0;
  endfunction

  // Builds a version-1 RFC 4122 UUID from its time, clock and node.
  function automatic logic [127:0] v1_uuid(input logic [59:0] t, input logic [13:0] c,
                                           input logic [47:0] node);
    return {t[31:0], t[47:32], 4'h1, t[59:48], 2'b10, c, node};
  endfunction

  // Version-1 UUID whose node matches the regenerated one, so it condenses compactly.
  function automatic logic [127:0] compact_uuid(input logic [59:0] t, input logic [13:0] c,
                                                input logic [6:0] salt);
    logic [63:0] ct;
    logic [63:0] cc;
    ct = rebase({4'd0, t});
    cc = {50'd0, c} ^ (ct & 64'h3fff);
    return v1_uuid(t, c, 48'(node_from_fields(ct >> 14, cc, {57'd0, salt})));
  endfunction

  // Serialises one UUID and queues every byte it must produce.
  task automatic queue_serial(input logic [63:0] hi, input logic [63:0] lo);
    logic [7:0]  sb [17];
    logic [63:0] node, clock, t, ct, cc, salt, v1, b0, b1;
    logic [7:0]  lead;
    logic [1:0]  kind;
    int unsigned start, len, count;
    ser_byte_t   e;
    start = 0;
    if (lo[63:62] == 2'b10 && hi[15:12] == 4'h1) begin
      node = lo & NODE48;
      clock = {50'd0, lo[61:48]};
      t = {4'd0, hi[11:0], hi[31:16], hi[63:32]};
      ct = rebase(t);
      cc = clock ^ (ct & 64'h3fff);
      salt = node & 64'h7f;
      ct = ct >> 14;
      if (node_from_fields(ct, cc, salt) == node) begin
        kind = KIND_COMPACT;
        v1 = (cc << 50) | (salt << 43) | 64'd1;
        b0 = ct >> 42;
        b1 = (ct << 22) | (v1 >> 42) | 64'd1;
      end else begin
        kind = KIND_EXPANDED;
        if ((node & MCAST64) == 0) t = rebase(t);
        t = t & TIME60;
        v1 = (clock << 50) | (node << 2);
        b0 = t >> 1;
        b1 = (t << 63) | (v1 >> 1);
      end
      sb[0] = 8'h00;
      for (int k = 0; k < 8; k++) begin
        sb[1 + k] = b0[63 - 8 * k -: 8];
        sb[9 + k] = b1[63 - 8 * k -: 8];
      end
      // Strip leading zero bytes, keeping at least four, then merge the prefix.
      start = 1;
      while (start < 13 && sb[start] == 8'h00) start++;
      len = 13 - start;
      lead = sb[start];
      if ((lead & PREFIX_TBL[len][1]) != 0) begin
        if ((lead & PREFIX_TBL[len][3]) != 0) begin
          start--;
          len++;
          if (len > 12) len = 12;
          sb[start] = sb[start] | PREFIX_TBL[len][0];
        end else begin
          sb[start] = lead | PREFIX_TBL[len][2];
        end
      end else begin
        sb[start] = lead | PREFIX_TBL[len][0];
      end
    end else begin
      kind = KIND_FULL;
      sb[0] = 8'h01;
      for (int k = 0; k < 8; k++) begin
        sb[1 + k] = hi[63 - 8 * k -: 8];
        sb[9 + k] = lo[63 - 8 * k -: 8];
      end
    end
    count = 17 - start;
    for (int unsigned k = 0; k < count; k++) begin
      e.data = sb[start + k];
      e.last = (k + 1 == count);
      e.kind = kind;
      ser_q = {ser_q, e};
    end
  endtask

  function automatic bit idle_roll();
    if (cyc >= 30000 && cyc < 60000) return 1'b0;
    return $urandom_range(99) < 37;
  endfunction

  task automatic add_uuid(input logic [127:0] u, input bit drain = 1'b0);
    uuid_item_t it;
    it.hi = u[127:64];
    it.lo = u[63:0];
    it.drain_first = drain;
    uuid_q = {uuid_q, it};
  endtask

  // Driver: offers queued UUIDs and predicts the bytes of each accepted transfer.
  always @(posedge clk) begin : drive
    logic       nv;
    uuid_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        queue_serial(in_uuid_high, in_uuid_low);
        nv = 1'b0;
      end
      if (!nv && uuid_q.size() > 0 && !idle_roll() &&
          (!uuid_q[0].drain_first || ser_q.size() == 0)) begin
        it = uuid_q.pop_front();
        in_uuid_high <= it.hi;
        in_uuid_low <= it.lo;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cyc == 3000) begin
      out_ready <= 1'b0;
      hold_left <= 799;
    end else begin
      out_ready <= !idle_roll();
    end
  end

  // Monitor: compares each byte transfer with the oldest prediction.
  always @(posedge clk) begin : check
    ser_byte_t e;
    if (rst_n && out_valid && out_ready) begin
      if (ser_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h last %0b kind %0d", out_out_byte, out_last_byte,
                   out_form_kind);
      end else begin
        e = ser_q.pop_front();
        if (e.data !== out_out_byte || e.last !== out_last_byte || e.kind !== out_form_kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d", e.data, e.last,
                     e.kind, out_out_byte, out_last_byte, out_form_kind);
        end
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stim
    logic [59:0] t;
    int unsigned r;
    // Directed: raw forms, zero time, zero condensed fields, multicast, extremes.
    add_uuid(128'h0);
    add_uuid({128{1'b1}});
    add_uuid({64'h0000000000001000, 64'h8000000000000000});
    add_uuid({64'h0000000000001000, 64'h8000010000000000});
    add_uuid(v1_uuid(60'(BASE_2016), 14'd0, 48'h010000000000));
    add_uuid(compact_uuid(60'(BASE_2016), 14'd0, 7'd0));
    add_uuid(compact_uuid(60'(BASE_2016 + 64'd1), 14'd1, 7'd1));
    add_uuid(compact_uuid(60'(BASE_2016) + 60'h4000, 14'h3fff, 7'h7f));
    add_uuid(compact_uuid({60{1'b1}}, 14'h3fff, 7'h7f));
    add_uuid(compact_uuid(60'd1, 14'd0, 7'd0));
    add_uuid(v1_uuid({60{1'b1}}, 14'h3fff, 48'hffffffffffff));
    add_uuid(v1_uuid({60{1'b1}}, 14'h3fff, 48'hfeffffffffff));
    add_uuid(v1_uuid(60'(BASE_2016), 14'd0, 48'h000000000001));
    add_uuid(v1_uuid(60'd1, 14'd0, 48'h0));
    add_uuid({64'h0000000000002000, 64'h8000000000000000});
    add_uuid({64'h0000000000001000, 64'hc000000000000000});
    add_uuid({64'h0000000000001000, 64'h4000000000000000});
    add_uuid({64'hffffffffffff1fff, 64'hbfffffffffffffff});
    add_uuid({64'hffffffffffffefff, 64'h8000000000000000});
    add_uuid(compact_uuid(60'(BASE_2016) + 60'h123456789, 14'h2aaa, 7'h55));
    // Random: compact-matching UUIDs, expanded ones and noise, mixed at random, mostly compact.
    for (int i = 0; i < 230; i++) begin
      r = $urandom_range(99);
      t = 60'({$urandom, $urandom});
      if ($urandom_range(3) == 0) t = 60'(BASE_2016) + 60'({$urandom, $urandom} >> $urandom_range(63));
      if (r < 55)
        add_uuid(compact_uuid(t, 14'($urandom), 7'($urandom)), i == 0 || i == 120);
      else if (r < 85)
        add_uuid(v1_uuid(t, 14'($urandom), {16'($urandom), $urandom}), i == 0 || i == 120);
      else
        add_uuid({$urandom, $urandom, $urandom, $urandom}, i == 0 || i == 120);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (uuid_q.size() == 0 && !in_valid && ser_q.size() == 0);
    repeat (500) @(posedge clk);
    if (mismatches == 0 && ser_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
